// ----- src/kht_pkg.sv -----
// shared constants, command and status types for the keyword hash table builder
// no dependencies
package kht_pkg;

  localparam int TABLE_BITS = 7;
  localparam int MAX_PROBE  = 7;
  localparam int HOME_SLOTS = 1 << TABLE_BITS;
  localparam int SLOTS      = HOME_SLOTS + MAX_PROBE;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int DIST_W     = $clog2(MAX_PROBE + 1);
  localparam int RND_W      = $clog2(SLOTS);

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  // prime is 2^40 + 0x1b3
  localparam int          FNV_SHIFT = 40;
  localparam logic [8:0]  FNV_LOW   = 9'h1b3;

  typedef struct packed {
    logic hash_step;   // fold a non-final byte
    logic start;       // fold final byte and load the insert
    logic read;        // read slot at idx + probe
    logic probe_inc;   // advance scan
    logic settle;      // scan ended: record overflow and first placement
    logic write_type;  // equal hash: update type only
    logic write_new;   // write carried entry into slot
    logic displace;    // pick up evicted entry
    logic set_ovf;     // displacement limit hit
  } cmd_t;

  typedef struct packed {
    logic present;     // slot under scan is occupied
    logic equal;       // occupied and holds the carried hash
    logic cont;        // scan moves on
    logic rounds_last; // next displacement reaches the limit
  } sts_t;

endpackage

// ----- src/kht_ctrl.sv -----
// controller state machine for the keyword hash table builder
// depends on kht_pkg
module kht_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_byte,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  kht_pkg::sts_t sts,
  output kht_pkg::cmd_t cmd
);
  import kht_pkg::*;

  typedef enum logic [1:0] {IDLE, RD, CHK, OUT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_stall  = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      IDLE: begin
        if (in_acc && in_last_byte) begin
          cmd.start = 1'b1;
          state_nxt = RD;
        end else if (in_acc) begin
          cmd.hash_step = 1'b1;
        end
      end
      RD: begin
        cmd.read  = 1'b1;
        state_nxt = CHK;
      end
      CHK: begin
        if (sts.cont) begin
          cmd.probe_inc = 1'b1;
          state_nxt     = RD;
        end else begin
          cmd.settle = 1'b1;
          if (sts.equal) begin
            cmd.write_type = 1'b1;
            state_nxt      = OUT;
            out_valid_nxt  = 1'b1;
          end else begin
            cmd.write_new = 1'b1;
            if (!sts.present) begin
              state_nxt     = OUT;
              out_valid_nxt = 1'b1;
            end else if (sts.rounds_last) begin
              cmd.set_ovf   = 1'b1;
              state_nxt     = OUT;
              out_valid_nxt = 1'b1;
            end else begin
              cmd.displace = 1'b1;
              state_nxt    = RD;
            end
          end
        end
      end
      OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/kht_dp.sv -----
// datapath: fnv-1a hash, slot table memory, present bits and insert registers
// depends on kht_pkg
module kht_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  kht_pkg::cmd_t cmd,
  output kht_pkg::sts_t sts,
  input  logic [7:0]    in_key_byte,
  input  logic [7:0]    in_type_tag,
  output logic [63:0]   out_key_hash,
  output logic [6:0]    out_home_slot,
  output logic [7:0]    out_placed_slot,
  output logic          out_probe_overflow
);
  import kht_pkg::*;

  logic [63:0] mem_hash [SLOTS];
  logic [7:0]  mem_type [SLOTS];
  logic [DIST_W-1:0] mem_dist [SLOTS];

  logic [SLOTS-1:0]      present_r;
  logic [63:0]           run_hash_r, res_hash_r, cur_hash_r, rd_hash_r;
  logic [7:0]            cur_type_r, rd_type_r;
  logic [DIST_W-1:0]     probe_r, rd_dist_r;
  logic [TABLE_BITS-1:0] idx_r;
  logic [RND_W-1:0]      rounds_r;
  logic [SLOT_W-1:0]     placed_r;
  logic                  first_r, ovf_r;

  logic [63:0]       mix, h_nxt;
  logic [SLOT_W-1:0] s;

  // x * prime = (x << 40) + x * 0x1b3, mod 2^64
  assign mix   = run_hash_r ^ {56'd0, in_key_byte};
  assign h_nxt = (mix << FNV_SHIFT) + 64'(mix * {55'd0, FNV_LOW});

  assign s = SLOT_W'(idx_r) + SLOT_W'(probe_r);

  assign sts.present     = present_r[s];
  assign sts.equal       = present_r[s] && (rd_hash_r == cur_hash_r);
  assign sts.cont        = present_r[s] && (rd_hash_r != cur_hash_r) &&
                           (rd_dist_r >= probe_r) && (probe_r < DIST_W'(MAX_PROBE));
  assign sts.rounds_last = (rounds_r == RND_W'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_hash_r <= mem_hash[s];
      rd_type_r <= mem_type[s];
      rd_dist_r <= mem_dist[s];
    end
    if (cmd.write_new) begin
      mem_hash[s] <= cur_hash_r;
      mem_type[s] <= cur_type_r;
      mem_dist[s] <= probe_r;
    end
    if (cmd.write_type) begin
      mem_type[s] <= cur_type_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      run_hash_r <= FNV_BASIS;
    end else begin
      if (cmd.write_new) present_r[s] <= 1'b1;
      if (cmd.hash_step) run_hash_r <= h_nxt;
      if (cmd.start)     run_hash_r <= FNV_BASIS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_hash_r <= h_nxt;
      cur_hash_r <= h_nxt;
      cur_type_r <= in_type_tag;
      idx_r      <= h_nxt[TABLE_BITS-1:0];
      probe_r    <= '0;
      rounds_r   <= '0;
      first_r    <= 1'b1;
      ovf_r      <= 1'b0;
      placed_r   <= SLOT_W'(h_nxt[TABLE_BITS-1:0]);
    end
    if (cmd.probe_inc) probe_r <= probe_r + DIST_W'(1);
    // probe limit at settle or displacement limit
    if (cmd.set_ovf || (cmd.settle && (probe_r == DIST_W'(MAX_PROBE)))) ovf_r <= 1'b1;
    if (cmd.settle) begin
      if (first_r) placed_r <= s;
    end
    if (cmd.displace) begin
      cur_hash_r <= rd_hash_r;
      cur_type_r <= rd_type_r;
      probe_r    <= (rd_dist_r > DIST_W'(MAX_PROBE)) ? DIST_W'(MAX_PROBE) : rd_dist_r;
      idx_r      <= rd_hash_r[TABLE_BITS-1:0];
      rounds_r   <= rounds_r + RND_W'(1);
      first_r    <= 1'b0;
    end
  end

  assign out_key_hash       = res_hash_r;
  assign out_home_slot      = res_hash_r[6:0];
  assign out_placed_slot    = 8'(placed_r);
  assign out_probe_overflow = ovf_r;

endmodule

// ----- src/keyword_hash_table_builder.sv -----
// keyword hash table builder: fnv-1a 64 hashing and robin hood table insert
// a non-final byte request is taken while idle; a final byte stalls the input
// through a read state and a check state per slot read (home slot, each probe step,
// each displacement), then the result request is offered and held until taken;
// sequential, one insert at a time; reset: sync active low, clears present marks
// and loads the offset basis; depends on kht_pkg, kht_ctrl, kht_dp
module keyword_hash_table_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  input  logic [7:0]  in_type_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_key_hash,
  output logic [6:0]  out_home_slot,
  output logic [7:0]  out_placed_slot,
  output logic        out_probe_overflow
);
  import kht_pkg::*;

  // commands from controller, status back from datapath
  cmd_t cmd;
  sts_t sts;

  // state machine: idle, read slot, check slot, hold result
  kht_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // hash, slot memory and result registers
  kht_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_key_byte        (in_key_byte),
    .in_type_tag        (in_type_tag),
    .out_key_hash       (out_key_hash),
    .out_home_slot      (out_home_slot),
    .out_placed_slot    (out_placed_slot),
    .out_probe_overflow (out_probe_overflow)
  );

endmodule

// ----- tb/sv/kht_checker.sv -----
// checker for the keyword hash table builder: watches both channels,
// predicts every insert result and compares it field by field
// depends on kht_pkg for table sizes and hash constants
module kht_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  input  logic [7:0]  in_type_tag,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_key_hash,
  input  logic [6:0]  out_home_slot,
  input  logic [7:0]  out_placed_slot,
  input  logic        out_probe_overflow,
  output int          fail_count,
  output int          pending_count,
  output int          insert_count,
  output int          overflow_count
);
  import kht_pkg::*;

  typedef struct packed {
    logic [63:0] key_hash;
    logic [6:0]  home_slot;
    logic [7:0]  placed_slot;
    logic        probe_overflow;
  } insert_result_t;

  localparam logic [63:0] FNV_PRIME = 64'h100000001b3;

  logic [63:0] model_hash;
  logic [63:0] tbl_hash [SLOTS];
  logic [7:0]  tbl_type [SLOTS];
  logic        tbl_present [SLOTS];
  int          tbl_dist [SLOTS];
  insert_result_t expected_inserts[$];

  assign pending_count = expected_inserts.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // robin hood insert, mirroring the table walk exactly
  function automatic insert_result_t robin_insert(input logic [63:0] h,
                                                  input logic [7:0] tag);
    insert_result_t r;
    logic [63:0] cur_hash;
    logic [7:0]  cur_type;
    logic        old_present;
    logic [63:0] old_hash;
    logic [7:0]  old_type;
    int          old_dist, idx, probe, rounds, s;
    bit          first;
    cur_hash = h;
    cur_type = tag;
    idx = int'(h[TABLE_BITS-1:0]);
    probe = 0;
    rounds = 0;
    first = 1;
    r.key_hash = h;
    r.home_slot = h[6:0];
    r.placed_slot = 8'(idx);
    r.probe_overflow = 1'b0;
    forever begin
      s = idx + probe;
      while (tbl_present[s] && tbl_hash[s] != cur_hash && tbl_dist[s] >= probe &&
             probe < MAX_PROBE) begin
        probe++;
        s = idx + probe;
      end
      if (probe >= MAX_PROBE) r.probe_overflow = 1'b1;
      if (tbl_present[s] && tbl_hash[s] == cur_hash) begin
        // equal hash: only the type is refreshed
        tbl_type[s] = cur_type;
        if (first) r.placed_slot = 8'(s);
        return r;
      end
      if (first) r.placed_slot = 8'(s);
      old_present = tbl_present[s];
      old_hash = tbl_hash[s];
      old_type = tbl_type[s];
      old_dist = tbl_dist[s];
      tbl_present[s] = 1'b1;
      tbl_hash[s] = cur_hash;
      tbl_type[s] = cur_type;
      tbl_dist[s] = probe;
      if (!old_present) return r;
      rounds++;
      if (rounds >= SLOTS) begin
        r.probe_overflow = 1'b1;
        return r;
      end
      cur_hash = old_hash;
      cur_type = old_type;
      probe = (old_dist > MAX_PROBE) ? MAX_PROBE : old_dist;
      idx = int'(old_hash[TABLE_BITS-1:0]);
      first = 0;
    end
  endfunction

  insert_result_t want, got;
  logic [63:0] folded;

  always @(posedge clk) begin
    if (!rst_n) begin
      model_hash <= FNV_BASIS;
      for (int i = 0; i < SLOTS; i++) begin
        tbl_present[i] = 1'b0;
        tbl_dist[i] = 0;
      end
      expected_inserts.delete();
      fail_count = 0;
      insert_count <= 0;
      overflow_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        folded = (model_hash ^ {56'd0, in_key_byte}) * FNV_PRIME;
        if (in_last_byte) begin
          want = robin_insert(folded, in_type_tag);
          expected_inserts.push_back(want);
          model_hash <= FNV_BASIS;
        end else begin
          model_hash <= folded;
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_key_hash, out_home_slot, out_placed_slot, out_probe_overflow};
        if (expected_inserts.size() == 0) begin
          report_mismatch("unexpected result key_hash", out_key_hash, 64'd0);
        end else begin
          want = expected_inserts.pop_front();
          insert_count <= insert_count + 1;
          if (want.probe_overflow) overflow_count <= overflow_count + 1;
          if (got.key_hash != want.key_hash)
            report_mismatch("key_hash", got.key_hash, want.key_hash);
          if (got.home_slot != want.home_slot)
            report_mismatch("home_slot", 64'(got.home_slot), 64'(want.home_slot));
          if (got.placed_slot != want.placed_slot)
            report_mismatch("placed_slot", 64'(got.placed_slot), 64'(want.placed_slot));
          if (got.probe_overflow != want.probe_overflow)
            report_mismatch("probe_overflow", 64'(got.probe_overflow),
                            64'(want.probe_overflow));
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// top of the keyword hash table builder testbench: clock, reset, key requests
// and the verdict; depends on kht_checker and the block itself
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_key_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [7:0]  in_type_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_key_hash;
  logic [6:0]  out_home_slot;
  logic [7:0]  out_placed_slot;
  logic        out_probe_overflow;

  int fail_count, pending_count, insert_count, overflow_count;
  int send_idle_pct = 0;   // chance per cycle the sender holds off
  int recv_stall_pct = 0;  // chance per cycle the receiver stalls
  int idle_cycles = 0;
  int request_count = 0;

  always #10 clk = ~clk;

  keyword_hash_table_builder dut (.*);

  kht_checker chk (.*);

  // receiver: random stall, refreshed every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog: cycles with no accepted request on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one byte request: optional random hold-off, then wait for acceptance
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [7:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_byte <= b;
    in_last_byte <= last;
    in_type_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    request_count++;
  endtask

  // keyword of random bytes; tag rides on the last byte, noise tags elsewhere
  task automatic send_keyword(input int len, input logic [7:0] tag);
    for (int i = 0; i < len - 1; i++)
      send_byte(8'($urandom), 1'b0, 8'($urandom));
    send_byte(8'($urandom), 1'b1, tag);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] tag;
    int phase_len;
    int klen;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme bytes, single-byte keywords, long keyword
    send_byte(8'h00, 1'b1, 8'h00);
    send_byte(8'hff, 1'b1, 8'hff);
    send_byte(8'hff, 1'b0, 8'h00);
    send_byte(8'h00, 1'b0, 8'hff);
    send_byte(8'h80, 1'b1, 8'h01);
    // repeat a keyword: equal hash rewrites only the type
    send_byte(8'h00, 1'b1, 8'h5a);
    send_byte(8'hff, 1'b1, 8'ha5);
    for (int i = 0; i < 12; i++) send_byte(8'(i * 21), 1'b0, 8'($urandom));
    send_byte(8'h7f, 1'b1, 8'h3c);
    drop_valid();

    // random phases: no idling, sender idle, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      phase_len = 0;
      while (phase_len < 120) begin
        tag = 8'($urandom);
        if ($urandom_range(9) == 0) begin
          // resend a short known keyword to hit the equal-hash path
          send_byte(8'h00, 1'b1, tag);
          phase_len++;
        end else begin
          // mostly short keywords, so the table fills and overflows
          klen = int'($urandom_range(1, 4));
          send_keyword(klen, tag);
          phase_len += klen;
        end
        if ($urandom_range(19) == 0) drop_valid();
      end
      drop_valid();
    end

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d byte requests, %0d inserts checked, %0d with probe overflow",
             request_count, insert_count, overflow_count);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- keyword_hash_table_builder.f -----
src/kht_pkg.sv
src/kht_ctrl.sv
src/kht_dp.sv
src/keyword_hash_table_builder.sv
tb/sv/kht_checker.sv
tb/sv/tb_top.sv
